/* rtl/som_pkg.sv */
// Shared constants of the self-organizing map training block.
// Used by som_theta and som_winner_and_weight_update; needs nothing.
`timescale 1ns / 1ps
package som_pkg;

    // Operation codes of an input item.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_RATE_GAIN  = 1'b0;
    localparam logic CFG_RATE_FLOOR = 1'b1;

    // Configuration reset values, Q0.16.
    localparam logic [15:0] RATE_GAIN_RST  = 16'd16384;
    localparam logic [15:0] RATE_FLOOR_RST = 16'd328;

    // exp(-1) in Q0.32 and the number of terms of the exp(-f) series.
    localparam logic [30:0] EXP_M1_Q32   = 31'd1580030169;
    localparam logic [3:0]  SERIES_TERMS = 4'd12;

    // Largest reported squared distance.
    localparam logic [33:0] DIST_MAX = 34'h3_FFFF_FFFF;

endpackage

/* rtl/som_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing else.
`timescale 1ns / 1ps
module som_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/som_vcell.sv */
// One cell of the training vector ring: holds one component and hands it on.
// Depends on nothing else.
`timescale 1ns / 1ps
module som_vcell (
    input  logic        i_clk,
    input  logic        i_ld,
    input  logic [15:0] i_ld_val,
    input  logic        i_shift,
    input  logic [15:0] i_next,
    output logic [15:0] o_val
);

    logic [15:0] r_val;

    // A direct write wins over the ring shift.
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_val <= i_ld_val;
        end else if (i_shift) begin
            r_val <= i_next;
        end
    end

    assign o_val = r_val;

endmodule

/* rtl/som_theta.sv */
// Neighborhood factor unit: theta = exp(-sqrt(n) * step / 2) in Q1.16.
// Uses som_pkg for the series length and the exp(-1) constant.
`timescale 1ns / 1ps
module som_theta #(
    parameter int NW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_n,
    input  logic [5:0]    i_st,
    output logic          o_done,
    output logic [16:0]   o_theta
);

    localparam int VW  = ((NW + 33) / 2) * 2;
    localparam int HW  = VW / 2;
    localparam int XW  = HW + 6;
    localparam int KW  = XW - 16;
    localparam int CW0 = $clog2(HW + 1);
    localparam int CNW = (CW0 > 6) ? CW0 : 6;

    localparam logic [32:0] EXP_M1_Q32_EXT = {2'b00, som_pkg::EXP_M1_Q32};

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_SQ   = 3'd1;
    localparam logic [2:0] T_MUL  = 3'd2;
    localparam logic [2:0] T_SMUL = 3'd3;
    localparam logic [2:0] T_SDIV = 3'd4;
    localparam logic [2:0] T_EXP  = 3'd5;
    localparam logic [2:0] T_FIN  = 3'd6;

    logic [2:0]     r_state;
    logic [VW-1:0]  r_v, r_r, r_bit;
    logic [5:0]     r_st;
    logic [KW-1:0]  r_k;
    logic [15:0]    r_f;
    logic [32:0]    r_term, r_sum, r_p;
    logic [31:0]    r_num;
    logic [3:0]     r_rem, r_i;
    logic [CNW-1:0] r_cnt;
    logic [16:0]    r_theta;
    logic           r_done;

    logic [VW:0]    sq_try;
    logic [XW-1:0]  x_prod, x_half;
    logic [48:0]    t_prod;
    logic [4:0]     d_try, d_rem;
    logic           d_ge;
    logic [31:0]    d_q;
    logic [64:0]    e_prod;
    logic [65:0]    f_prod;
    logic [34:0]    f_round;

    // Datapath of the current step.
    always_comb begin
        sq_try  = {1'b0, r_r} + {1'b0, r_bit};
        x_prod  = XW'(r_r[HW-1:0]) * XW'(r_st);
        x_half  = x_prod >> 1;
        t_prod  = r_term * r_f;
        d_try   = {r_rem, r_num[31]};
        d_ge    = d_try >= {1'b0, r_i};
        d_rem   = d_ge ? d_try - {1'b0, r_i} : d_try;
        d_q     = {r_num[30:0], d_ge};
        e_prod  = 65'(r_p) * 65'(EXP_M1_Q32_EXT) + (65'd1 << 31);
        f_prod  = r_sum * r_p;
        f_round = {1'b0, f_prod[65:32]} + 35'd32768;
    end

    // Sequencer: square root, series, powers of exp(-1), final product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                T_IDLE: begin
                    if (i_start) begin
                        r_v     <= VW'({i_n, 32'b0});
                        r_r     <= '0;
                        r_bit   <= VW'(1) << (VW - 2);
                        r_st    <= i_st;
                        r_cnt   <= '0;
                        r_state <= T_SQ;
                    end
                end
                T_SQ: begin
                    if ({1'b0, r_v} >= sq_try) begin
                        r_v <= r_v - sq_try[VW-1:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNW'(HW - 1)) begin
                        r_state <= T_MUL;
                    end
                end
                T_MUL: begin
                    r_k <= x_half[XW-1:16];
                    r_f <= x_half[15:0];
                    if (x_half[XW-1:16] >= KW'(12)) begin
                        r_theta <= '0;
                        r_done  <= 1'b1;
                        r_state <= T_IDLE;
                    end else begin
                        r_term  <= 33'd1 << 32;
                        r_sum   <= 33'd1 << 32;
                        r_i     <= 4'd1;
                        r_state <= T_SMUL;
                    end
                end
                T_SMUL: begin
                    r_num   <= t_prod[47:16];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= T_SDIV;
                end
                T_SDIV: begin
                    r_num <= d_q;
                    r_rem <= d_rem[3:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNW'(31)) begin
                        r_term <= {1'b0, d_q};
                        if (r_i[0]) begin
                            r_sum <= r_sum - {1'b0, d_q};
                        end else begin
                            r_sum <= r_sum + {1'b0, d_q};
                        end
                        if (r_i == som_pkg::SERIES_TERMS) begin
                            r_p     <= 33'd1 << 32;
                            r_cnt   <= '0;
                            r_state <= T_EXP;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= T_SMUL;
                        end
                    end
                end
                T_EXP: begin
                    if (r_cnt[3:0] == r_k[3:0]) begin
                        r_state <= T_FIN;
                    end else begin
                        r_p   <= e_prod[64:32];
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                T_FIN: begin
                    r_theta <= f_round[32:16];
                    r_done  <= 1'b1;
                    r_state <= T_IDLE;
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_theta = r_theta;

endmodule

/* rtl/som_winner_and_weight_update.sv */
// A load item or a train item without last is stored and leaves busy low. A train
// item with last starts the winner search, then the rate division, then per neuron
// the theta unit and the weight writes; the result strobe follows in the cycle
// after the last write.
// One item at a time; start is taken only while busy is low. Synchronous
// active-low reset clears the step count and control; the weights are not cleared.
`timescale 1ns / 1ps
module som_winner_and_weight_update #(
    parameter int MAP_SIDE   = 8,
    parameter int VECTOR_LEN = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [2:0]  i_neuron_row,
    input  logic [2:0]  i_neuron_col,
    input  logic [1:0]  i_component,
    input  logic [15:0] i_value,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [2:0]  o_winner_row,
    output logic [2:0]  o_winner_col,
    output logic [31:0] o_step_count,
    output logic [33:0] o_best_dist_sq
);

    localparam int NEURONS = MAP_SIDE * MAP_SIDE;
    localparam int TOT     = NEURONS * VECTOR_LEN;
    localparam int ADW     = $clog2(TOT);
    localparam int RW      = $clog2(MAP_SIDE);
    localparam int KW      = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
    localparam int NW      = $clog2(2 * (MAP_SIDE - 1) * (MAP_SIDE - 1) + 1);
    localparam int AW      = 33 + $clog2(VECTOR_LEN);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_RATE   = 4'd2;
    localparam logic [3:0] S_TSTART = 4'd3;
    localparam logic [3:0] S_TWAIT  = 4'd4;
    localparam logic [3:0] S_GAIN   = 4'd5;
    localparam logic [3:0] S_RD     = 4'd6;
    localparam logic [3:0] S_WR     = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]     r_state;
    logic [15:0]    r_gain, r_floor;
    logic [31:0]    r_step;
    logic [ADW:0]   r_addr;
    logic           r_dv;
    logic [KW-1:0]  r_dk;
    logic [RW-1:0]  r_dr, r_dc;
    logic [AW-1:0]  r_acc, r_best;
    logic [RW-1:0]  r_wr, r_wc;
    logic [15:0]    r_dsh, r_drem, r_dq;
    logic [4:0]     r_dcnt;
    logic [16:0]    r_rate;
    logic [18:0]    r_g;
    logic [RW-1:0]  r_ur, r_uc;
    logic [KW-1:0]  r_uk;
    logic [ADW-1:0] r_uaddr;

    logic           accept, ld_ok, cmp_ok, iss, shift;
    logic [ADW-1:0] ld_addr, raddr, waddr;
    logic           we;
    logic [15:0]    wdata, rdata, x_head;
    logic [15:0]    v_cell [VECTOR_LEN];
    logic signed [16:0] diff;
    logic signed [33:0] dsq;
    logic [AW-1:0]  tot;
    logic [16:0]    d_try;
    logic           d_ge;
    logic [16:0]    d_rem;
    logic [15:0]    d_q;
    logic [RW-1:0]  dr, dc;
    logic [2*RW:0]  n_sum;
    logic [5:0]     st;
    logic           th_done;
    logic [16:0]    th_val;
    logic [34:0]    g_prod;
    logic [16:0]    mag;
    logic [35:0]    m_prod;
    logic [20:0]    dl;
    logic signed [22:0] nw, nw_abs;
    logic [AW+33:0] best_ext;
    logic [RW+2:0]  wr_ext, wc_ext;

    // Input transfer decode.
    always_comb begin
        busy    = r_state != S_IDLE;
        accept  = start && !busy;
        ld_ok   = ({3'b0, i_neuron_row} < 6'(MAP_SIDE)) &&
                  ({3'b0, i_neuron_col} < 6'(MAP_SIDE)) &&
                  ({3'b0, i_component} < 5'(VECTOR_LEN));
        cmp_ok  = {3'b0, i_component} < 5'(VECTOR_LEN);
        ld_addr = ADW'((int'(i_neuron_row) * MAP_SIDE + int'(i_neuron_col)) * VECTOR_LEN
                       + int'(i_component));
    end

    // Weight store.
    always_comb begin
        iss   = (r_state == S_SEARCH) && (r_addr != (ADW+1)'(TOT));
        raddr = (r_state == S_SEARCH) ? r_addr[ADW-1:0] : r_uaddr;
        we    = (accept && i_op == som_pkg::OP_LOAD && ld_ok) || (r_state == S_WR);
        waddr = (r_state == S_WR) ? r_uaddr : ld_addr;
        wdata = (r_state == S_WR) ? nw_abs[15:0] : i_value;
        if (r_state == S_WR && nw_abs > 23'sd32767) begin
            wdata = 16'd32767;
        end
    end

    som_ram #(
        .WIDTH (16),
        .DEPTH (TOT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Training vector ring; the head cell always holds the component in use.
    assign shift  = r_dv || (r_state == S_WR);
    assign x_head = v_cell[0];

    for (genvar j = 0; j < VECTOR_LEN; j++) begin : g_cell
        som_vcell u_cell (
            .i_clk    (i_clk),
            .i_ld     (accept && i_op == som_pkg::OP_TRAIN && cmp_ok &&
                       {3'b0, i_component} == 5'(j)),
            .i_ld_val (i_value),
            .i_shift  (shift),
            .i_next   (v_cell[(j + 1) % VECTOR_LEN]),
            .o_val    (v_cell[j])
        );
    end

    // Distance, rate division and weight update arithmetic.
    always_comb begin
        diff   = {x_head[15], x_head} - {rdata[15], rdata};
        dsq    = diff * diff;
        tot    = r_acc + AW'(dsq[32:0]);
        d_try  = {r_drem, r_dsh[15]};
        d_ge   = {16'b0, d_try} >= {1'b0, r_step};
        d_rem  = d_ge ? d_try - r_step[16:0] : d_try;
        d_q    = {r_dq[14:0], d_ge};
        dr     = (r_ur > r_wr) ? r_ur - r_wr : r_wr - r_ur;
        dc     = (r_uc > r_wc) ? r_uc - r_wc : r_wc - r_uc;
        n_sum  = (2*RW+1)'(dr) * (2*RW+1)'(dr) + (2*RW+1)'(dc) * (2*RW+1)'(dc);
        st     = (r_step > 32'd32) ? 6'd32 : r_step[5:0];
        g_prod = 35'(r_rate) * 35'(th_val) + 35'd32768;
        mag    = diff[16] ? 17'(-diff) : 17'(diff);
        m_prod = 36'(mag) * 36'(r_g);
        dl     = 21'((37'(m_prod) + 37'd32768) >> 16);
        nw     = diff[16] ? 23'({{7{rdata[15]}}, rdata}) - signed'({2'b0, dl})
                          : 23'({{7{rdata[15]}}, rdata}) + signed'({2'b0, dl});
        nw_abs = (nw < 0) ? -nw : nw;
    end

    som_theta #(
        .NW (NW)
    ) u_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_TSTART),
        .i_n     (NW'(n_sum)),
        .i_st    (st),
        .o_done  (th_done),
        .o_theta (th_val)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= som_pkg::RATE_GAIN_RST;
            r_floor <= som_pkg::RATE_FLOOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                som_pkg::CFG_RATE_GAIN:  r_gain  <= i_cfg_data;
                som_pkg::CFG_RATE_FLOOR: r_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_dv <= iss;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_op == som_pkg::OP_TRAIN && i_last) begin
                        if (r_step != '1) begin
                            r_step <= r_step + 1'b1;
                        end
                        r_addr  <= '0;
                        r_dk    <= '0;
                        r_dr    <= '0;
                        r_dc    <= '0;
                        r_acc   <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (iss) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_dv) begin
                        if (r_dk == KW'(VECTOR_LEN - 1)) begin
                            r_dk  <= '0;
                            r_acc <= '0;
                            if ((r_dr == '0 && r_dc == '0) || tot < r_best) begin
                                r_best <= tot;
                                r_wr   <= r_dr;
                                r_wc   <= r_dc;
                            end
                            if (r_dc == RW'(MAP_SIDE - 1)) begin
                                r_dc <= '0;
                                r_dr <= r_dr + 1'b1;
                                if (r_dr == RW'(MAP_SIDE - 1)) begin
                                    r_dsh   <= r_gain;
                                    r_drem  <= '0;
                                    r_dcnt  <= '0;
                                    r_state <= S_RATE;
                                end
                            end else begin
                                r_dc <= r_dc + 1'b1;
                            end
                        end else begin
                            r_dk  <= r_dk + 1'b1;
                            r_acc <= tot;
                        end
                    end
                end
                S_RATE: begin
                    r_drem <= d_rem[15:0];
                    r_dq   <= d_q;
                    r_dsh  <= r_dsh << 1;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'd15) begin
                        r_rate  <= {1'b0, d_q} + {1'b0, r_floor};
                        r_ur    <= '0;
                        r_uc    <= '0;
                        r_uk    <= '0;
                        r_uaddr <= '0;
                        r_state <= S_TSTART;
                    end
                end
                S_TSTART: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (th_done) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: begin
                    r_g     <= g_prod[34:16];
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_uaddr <= r_uaddr + 1'b1;
                    if (r_uk == KW'(VECTOR_LEN - 1)) begin
                        r_uk    <= '0;
                        r_state <= S_TSTART;
                        if (r_uc == RW'(MAP_SIDE - 1)) begin
                            r_uc <= '0;
                            r_ur <= r_ur + 1'b1;
                            if (r_ur == RW'(MAP_SIDE - 1)) begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_uc <= r_uc + 1'b1;
                        end
                    end else begin
                        r_uk    <= r_uk + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result transfer.
    always_comb begin
        best_ext       = (AW+34)'(r_best);
        wr_ext         = (RW+3)'(r_wr);
        wc_ext         = (RW+3)'(r_wc);
        o_valid        = r_state == S_DONE;
        o_winner_row   = wr_ext[2:0];
        o_winner_col   = wc_ext[2:0];
        o_step_count   = r_step;
        o_best_dist_sq = (best_ext > (AW+34)'(som_pkg::DIST_MAX)) ? som_pkg::DIST_MAX
                                                                  : best_ext[33:0];
    end

endmodule
